### hw/rtl/ccv_pkg.sv
package ccv_pkg;

  localparam int HEADER_BYTES    = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  // container magic, first byte in the low lane
  localparam logic [31:0] MAGIC_WORD  = 32'h584E494D;
  localparam logic [15:0] VERSION_ONE = 16'd1;

  localparam logic KIND_DESC    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // everything one input word causes: an optional descriptor and an optional verdict
  typedef struct packed {
    logic        has_desc;
    logic [31:0] tag;
    logic [31:0] len;
    logic [31:0] pay;
    logic        ovf;
    logic        has_verdict;
    logic        magic_ok;
    logic        version_ok;
    logic        length_ok;
    logic        crc_ok;
    logic        ovr_seen;
  } ccv_evt_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_length;
    logic [31:0] payload_offset;
    logic        magic_ok;
    logic        version_ok;
    logic        length_ok;
    logic        crc_ok;
    logic        overrun_flag;
    logic        last_of_run;
  } ccv_res_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

### hw/rtl/ccv_if.sv
interface ccv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ccv_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] chunk_tag;
  logic [31:0] chunk_length;
  logic [31:0] payload_offset;
  logic        magic_ok;
  logic        version_ok;
  logic        length_ok;
  logic        crc_ok;
  logic        overrun_flag;
  logic        last_of_run;

  modport source (output valid, output result_kind, output chunk_tag, output chunk_length,
                  output payload_offset, output magic_ok, output version_ok,
                  output length_ok, output crc_ok, output overrun_flag,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input chunk_tag, input chunk_length,
                  input payload_offset, input magic_ok, input version_ok,
                  input length_ok, input crc_ok, input overrun_flag,
                  input last_of_run, output ready);
endinterface

### hw/rtl/ccv_front.sv
module ccv_front import ccv_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ccv_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output ccv_evt_t   evt
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_STOP = 2'd3;

  logic [OFFSET_BITS-1:0] ofs_r, ofs_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [15:0] ver_r, ver_nxt;
  logic [31:0] decl_r, decl_nxt;
  logic [31:0] scrc_r, scrc_nxt;
  logic        magic_r, magic_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [32:0] nco_r, nco_nxt;
  logic        ovs_r, ovs_nxt;

  logic                   take;
  logic [7:0]             b;
  logic [OFFSET_BITS-1:0] o;
  logic                   in_hdr;
  logic [1:0]             ph;
  logic [2:0]             h;
  logic [31:0]            tag_w, len_w;
  logic [33:0]            pay, fin, fin_rnd;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && !q_full;
  assign push        = take && (evt.has_desc || evt.has_verdict);

  always_comb begin
    ofs_nxt   = ofs_r;
    crc_nxt   = crc_r;
    ver_nxt   = ver_r;
    decl_nxt  = decl_r;
    scrc_nxt  = scrc_r;
    magic_nxt = magic_r;
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    nco_nxt   = nco_r;
    ovs_nxt   = ovs_r;
    evt       = '0;
    b         = in_ch.data_byte;
    o         = ofs_r;
    in_hdr    = ofs_r < OFFSET_BITS'(HEADER_BYTES);
    ph        = phase_r;
    h         = hcnt_r;
    tag_w     = tag_r;
    len_w     = len_r;
    pay       = {1'b0, nco_r} + 34'd8;
    fin       = pay + {2'b00, len_w};
    fin_rnd   = fin + 34'd3;

    if (take) begin
      if (in_hdr) begin
        case (o[3:0]) inside
          [4'd0:4'd3]: begin
            if (b != MAGIC_WORD[{o[1:0], 3'b000} +: 8]) magic_nxt = 1'b0;
          end
          4'd4: ver_nxt[7:0]  = b;
          4'd5: ver_nxt[15:8] = b;
          [4'd8:4'd11]:  decl_nxt[{o[1:0], 3'b000} +: 8] = b;
          [4'd12:4'd15]: scrc_nxt[{o[1:0], 3'b000} +: 8] = b;
          default: ;
        endcase
      end else begin
        crc_nxt = crc_byte(crc_r, b);
      end

      if (magic_r && !in_hdr && phase_r != PH_STOP) begin
        // chunk start: stop quietly if the header cannot fit
        if (phase_r == PH_WAIT && 33'(o) == nco_r) begin
          if (pay > {2'b00, decl_r}) begin
            ph = PH_STOP;
          end else begin
            ph = PH_HDR;
            h  = 3'd0;
          end
        end
        phase_nxt = ph;
        hcnt_nxt  = h;
        if (ph == PH_HDR) begin
          if (!h[2]) begin
            tag_w = (h == 3'd0) ? 32'h0 : tag_r;
            tag_w[{h[1:0], 3'b000} +: 8] = b;
            tag_nxt = tag_w;
          end else begin
            len_w = (h == 3'd4) ? 32'h0 : len_r;
            len_w[{h[1:0], 3'b000} +: 8] = b;
            len_nxt = len_w;
          end
          fin     = pay + {2'b00, len_w};
          fin_rnd = fin + 34'd3;
          if (h == 3'd7) begin
            hcnt_nxt     = 3'd0;
            evt.has_desc = 1'b1;
            evt.tag      = tag_r;
            evt.len      = len_w;
            evt.pay      = pay[31:0];
            if (fin > {2'b00, decl_r}) begin
              ovs_nxt   = 1'b1;
              phase_nxt = PH_STOP;
              evt.ovf   = 1'b1;
            end else begin
              nco_nxt   = {fin_rnd[32:2], 2'b00};
              phase_nxt = PH_WAIT;
            end
          end else begin
            hcnt_nxt = h + 3'd1;
          end
        end
      end

      ofs_nxt = o + OFFSET_BITS'(1);

      if (in_ch.last_byte) begin
        evt.has_verdict = 1'b1;
        evt.ovr_seen    = ovs_nxt;
        if (ofs_nxt >= OFFSET_BITS'(HEADER_BYTES)) begin
          evt.magic_ok   = magic_nxt;
          evt.version_ok = (ver_nxt == VERSION_ONE);
          evt.length_ok  = (decl_nxt == 32'(ofs_nxt));
          evt.crc_ok     = ((crc_nxt ^ CRC_INIT) == scrc_nxt);
        end
        // next word opens a new container
        ofs_nxt   = '0;
        crc_nxt   = CRC_INIT;
        ver_nxt   = '0;
        decl_nxt  = '0;
        scrc_nxt  = '0;
        magic_nxt = 1'b1;
        phase_nxt = PH_WAIT;
        hcnt_nxt  = '0;
        tag_nxt   = '0;
        len_nxt   = '0;
        nco_nxt   = 33'(HEADER_BYTES);
        ovs_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r   <= '0;
      crc_r   <= CRC_INIT;
      ver_r   <= '0;
      decl_r  <= '0;
      scrc_r  <= '0;
      magic_r <= 1'b1;
      phase_r <= PH_WAIT;
      hcnt_r  <= '0;
      tag_r   <= '0;
      len_r   <= '0;
      nco_r   <= 33'(HEADER_BYTES);
      ovs_r   <= 1'b0;
    end else begin
      ofs_r   <= ofs_nxt;
      crc_r   <= crc_nxt;
      ver_r   <= ver_nxt;
      decl_r  <= decl_nxt;
      scrc_r  <= scrc_nxt;
      magic_r <= magic_nxt;
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      nco_r   <= nco_nxt;
      ovs_r   <= ovs_nxt;
    end
  end

endmodule

### hw/rtl/ccv_queue.sv
module ccv_queue import ccv_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ccv_evt_t din,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output ccv_evt_t dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ccv_evt_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_pop;

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign valid  = (cnt_r != '0);
  assign dout   = mem_r[rd_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/ccv_back.sv
module ccv_back import ccv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  ccv_evt_t   q_evt,
  output logic       pop,
  ccv_out_if.source  out_ch
);

  logic     out_valid_r, out_valid_nxt;
  logic     done_r, done_nxt;
  ccv_res_t res_r, res_nxt;
  logic     load;
  logic     emit_desc;

  assign load      = q_valid && (!out_valid_r || out_ch.ready);
  assign emit_desc = q_evt.has_desc && !done_r;

  always_comb begin
    pop      = 1'b0;
    done_nxt = done_r;
    res_nxt  = res_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (emit_desc) begin
        res_nxt.result_kind    = KIND_DESC;
        res_nxt.chunk_tag      = q_evt.tag;
        res_nxt.chunk_length   = q_evt.len;
        res_nxt.payload_offset = q_evt.pay;
        res_nxt.overrun_flag   = q_evt.ovf;
        res_nxt.last_of_run    = !q_evt.has_verdict;
        // hold the entry when its verdict still has to follow
        if (q_evt.has_verdict) done_nxt = 1'b1;
        else                   pop      = 1'b1;
      end else begin
        res_nxt.result_kind  = KIND_VERDICT;
        res_nxt.magic_ok     = q_evt.magic_ok;
        res_nxt.version_ok   = q_evt.version_ok;
        res_nxt.length_ok    = q_evt.length_ok;
        res_nxt.crc_ok       = q_evt.crc_ok;
        res_nxt.overrun_flag = q_evt.ovr_seen;
        res_nxt.last_of_run  = 1'b1;
        pop      = 1'b1;
        done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = res_r.result_kind;
  assign out_ch.chunk_tag      = res_r.chunk_tag;
  assign out_ch.chunk_length   = res_r.chunk_length;
  assign out_ch.payload_offset = res_r.payload_offset;
  assign out_ch.magic_ok       = res_r.magic_ok;
  assign out_ch.version_ok     = res_r.version_ok;
  assign out_ch.length_ok      = res_r.length_ok;
  assign out_ch.crc_ok         = res_r.crc_ok;
  assign out_ch.overrun_flag   = res_r.overrun_flag;
  assign out_ch.last_of_run    = res_r.last_of_run;

endmodule

### hw/rtl/chunk_container_validator.sv
// Chunk container validator. Feed the container one byte per word on in_ch, with
// last_byte set on the final byte. The block checks the 16-byte header (magic,
// version, declared length, stored CRC), runs a reflected CRC-32 over the body and
// walks the top-level chunks, sending one descriptor word per chunk on out_ch and a
// verdict word after the last byte; the final word caused by an input byte carries
// last_of_run. An input byte is taken every cycle while the event queue has room:
// the front end decodes and updates the CRC for one byte per cycle, so the rate is
// one byte per clock. out_ch moves one word per clock while ready is high, so a
// byte that both closes a chunk header and ends the container yields two words;
// the queue of QUEUE_DEPTH events soaks that up and lets out_ch stall without
// blocking input until the queue fills. No clearing pass runs after reset.
module chunk_container_validator import ccv_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ccv_in_if.sink    in_ch,
  ccv_out_if.source out_ch
);

  // event words between the decode front end and the result back end
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  ccv_evt_t q_din;
  ccv_evt_t q_dout;

  // decode bytes, track header fields, CRC and chunk walk
  ccv_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (q_push),
    .evt    (q_din)
  );

  // hold events so either side can stall
  ccv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  // split each event into result words and drive the output register
  ccv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_evt   (q_dout),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### dv/chunk_container_validator_test.sv
`timescale 1ns / 100ps

module chunk_container_validator_test;
  import ccv_pkg::*;

  // Overall cycle budget; a correct run needs only a small fraction of it.
  localparam int CYCLE_LIMIT = 200000;
  // Quiet cycles after the last expected word, long enough to catch strays.
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  // Walker states, same encoding as the block's walk phase.
  typedef enum logic [1:0] {
    WALK_SEEK    = 2'd0,
    WALK_HEADER  = 2'd1,
    WALK_STOPPED = 2'd3
  } walk_t;

  // Damage that the container builder can inject.
  typedef enum int {
    FAULT_NONE,
    FAULT_MAGIC,
    FAULT_VERSION,
    FAULT_LENGTH,
    FAULT_CRC,
    FAULT_OVERRUN,
    FAULT_TAIL,
    FAULT_TRUNCATE,
    FAULT_COUNT
  } fault_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n;

  ccv_in_if  in_ch();
  ccv_out_if out_ch();

  chunk_container_validator dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the block's container state.
  logic [31:0] rx_count;
  logic [31:0] body_crc;
  logic [15:0] version_word;
  logic [31:0] declared_len;
  logic [31:0] header_crc;
  logic        magic_match;
  walk_t       walk_state;
  logic [2:0]  hdr_idx;
  logic [31:0] chunk_id;
  logic [31:0] chunk_size;
  logic [63:0] chunk_start;
  logic        overran;

  // Result words still owed by the block, oldest first.
  ccv_res_t awaited_words[$];

  int  mismatches = 0;
  int  cycle_count;
  // Set to hold both sides at full rate.
  bit  steady_flow;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflected CRC-32, one bit at a time, LSB of the data first.
  function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] body_checksum(input byte_q_t body);
    logic [31:0] acc;
    acc = CRC_INIT;
    foreach (body[i]) acc = crc32_update(acc, body[i]);
    return ~acc;
  endfunction

  function automatic string word_text(input ccv_res_t w);
    return $sformatf("kind=%0d tag=%h len=%h pay=%h m/v/l/c=%b%b%b%b ovf=%b last=%b",
                     w.result_kind, w.chunk_tag, w.chunk_length, w.payload_offset,
                     w.magic_ok, w.version_ok, w.length_ok, w.crc_ok,
                     w.overrun_flag, w.last_of_run);
  endfunction

  task automatic clear_tracker();
    rx_count     = '0;
    body_crc     = CRC_INIT;
    version_word = '0;
    declared_len = '0;
    header_crc   = '0;
    magic_match  = 1'b1;
    walk_state   = WALK_SEEK;
    hdr_idx      = '0;
    chunk_id     = '0;
    chunk_size   = '0;
    chunk_start  = 64'(HEADER_BYTES);
    overran      = 1'b0;
  endtask

  // Advance the shadow state by one accepted byte and queue the words it owes.
  task automatic track_container_byte(input logic [7:0] b, input logic last);
    ccv_res_t    words[$];
    ccv_res_t    w;
    logic [31:0] o;
    logic [63:0] pay;
    logic [63:0] stop;
    o = rx_count;

    // Header fields land by position; anything past the header feeds the CRC.
    if (o < 4) begin
      if (b != MAGIC_WORD[8*o +: 8]) magic_match = 1'b0;
    end else if (o == 4) begin
      version_word[7:0] = b;
    end else if (o == 5) begin
      version_word[15:8] = b;
    end else if (o >= 8 && o < 12) begin
      declared_len[8*(o-8) +: 8] = b;
    end else if (o >= 12 && o < 16) begin
      header_crc[8*(o-12) +: 8] = b;
    end
    if (o >= HEADER_BYTES) body_crc = crc32_update(body_crc, b);

    // Chunk walk: a bad magic or a stopped walk ignores the rest of the body.
    if (magic_match && o >= HEADER_BYTES && walk_state != WALK_STOPPED) begin
      if (walk_state == WALK_SEEK && {32'd0, o} == chunk_start) begin
        // Fewer than 8 bytes left before the declared end: stop without a word.
        if (chunk_start + 64'd8 > {32'd0, declared_len}) begin
          walk_state = WALK_STOPPED;
        end else begin
          walk_state = WALK_HEADER;
          hdr_idx    = '0;
        end
      end
      if (walk_state == WALK_HEADER) begin
        if (hdr_idx < 4) chunk_id[8*hdr_idx +: 8] = b;
        else chunk_size[8*(hdr_idx-4) +: 8] = b;
        if (hdr_idx == 7) begin
          pay  = chunk_start + 64'd8;
          stop = pay + {32'd0, chunk_size};
          hdr_idx = '0;
          w = '0;
          w.result_kind    = KIND_DESC;
          w.chunk_tag      = chunk_id;
          w.chunk_length   = chunk_size;
          w.payload_offset = pay[31:0];
          if (stop > {32'd0, declared_len}) begin
            // Payload runs past the declared end: flag it and stop walking.
            overran        = 1'b1;
            walk_state     = WALK_STOPPED;
            w.overrun_flag = 1'b1;
          end else begin
            chunk_start = (stop + 64'd3) & ~64'd3;
            walk_state  = WALK_SEEK;
          end
          words.push_back(w);
        end else begin
          hdr_idx = hdr_idx + 3'd1;
        end
      end
    end

    rx_count = o + 32'd1;

    if (last) begin
      w = '0;
      w.result_kind = KIND_VERDICT;
      // A container shorter than the header gets all checks cleared.
      if (rx_count >= HEADER_BYTES) begin
        w.magic_ok   = magic_match;
        w.version_ok = (version_word == VERSION_ONE);
        w.length_ok  = (declared_len == rx_count);
        w.crc_ok     = (~body_crc == header_crc);
      end
      w.overrun_flag = overran;
      words.push_back(w);
      clear_tracker();
    end

    if (words.size() > 0) words[words.size()-1].last_of_run = 1'b1;
    foreach (words[i]) awaited_words.push_back(words[i]);
  endtask

  // Drive one byte at the falling edge, hold it until accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!steady_flow) begin
      while ($urandom_range(99) < 37) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_container_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_container(input byte_q_t img, inout int sent);
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
    sent += img.size();
  endtask

  // Prepend the 16-byte header; the two reserved bytes carry random filler.
  task automatic wrap_header(input byte_q_t body, input logic [15:0] ver,
                             input logic [31:0] declared, input logic [31:0] stored,
                             output byte_q_t img);
    img = {};
    for (int i = 0; i < 4; i++) img.push_back(MAGIC_WORD[8*i +: 8]);
    img.push_back(ver[7:0]);
    img.push_back(ver[15:8]);
    img.push_back(8'($urandom));
    img.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) img.push_back(declared[8*i +: 8]);
    for (int i = 0; i < 4; i++) img.push_back(stored[8*i +: 8]);
    foreach (body[i]) img.push_back(body[i]);
  endtask

  // Build one container with random chunks, then apply the requested damage.
  task automatic build_container(input fault_t fault, input int max_chunks,
                                 output byte_q_t img);
    byte_q_t     body;
    logic [31:0] size;
    logic [31:0] declared;
    logic [31:0] stored;
    logic [15:0] ver;
    int          pick;
    int          cut;
    int          pos;
    body = {};
    repeat ($urandom_range(0, max_chunks)) begin
      repeat (4) body.push_back(8'($urandom));
      pick = $urandom_range(0, 9);
      if (pick < 7) size = $urandom_range(0, 12);
      else if (pick < 9) size = $urandom_range(13, 40);
      else size = 0;
      for (int i = 0; i < 4; i++) body.push_back(size[8*i +: 8]);
      repeat (size) body.push_back(8'($urandom));
      while (body.size() % 4 != 0) body.push_back(8'($urandom));
    end
    if (fault == FAULT_OVERRUN) begin
      // Final chunk claims more payload than the container holds.
      repeat (4) body.push_back(8'($urandom));
      if ($urandom_range(0, 1)) size = $urandom_range(1, 64);
      else size = 32'h8000_0000 | $urandom;
      for (int i = 0; i < 4; i++) body.push_back(size[8*i +: 8]);
      repeat ($urandom_range(0, (size > 4) ? 3 : size - 1)) body.push_back(8'($urandom));
    end
    if (fault == FAULT_TAIL) begin
      // Leave too few bytes for another chunk header.
      repeat ($urandom_range(1, 7)) body.push_back(8'($urandom));
    end

    stored   = body_checksum(body);
    declared = HEADER_BYTES + body.size();
    ver      = VERSION_ONE;
    case (fault)
      FAULT_VERSION: begin
        ver = 16'($urandom);
        if (ver == VERSION_ONE) ver = ver ^ 16'h0100;
      end
      FAULT_LENGTH: begin
        pick = $urandom_range(0, 2);
        if (pick == 0) declared = $urandom;
        else if (pick == 1) declared = declared + $urandom_range(1, 8);
        else declared = declared - $urandom_range(1, 8);
      end
      FAULT_CRC: stored = stored ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    wrap_header(body, ver, declared, stored, img);

    if (fault == FAULT_MAGIC) begin
      pos = $urandom_range(0, 3);
      img[pos] = img[pos] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (fault == FAULT_TRUNCATE) begin
      // Cuts land inside the header, or for half the images with a body, in the body.
      if ($urandom_range(0, 1) || img.size() <= HEADER_BYTES) cut = $urandom_range(1, 15);
      else cut = $urandom_range(HEADER_BYTES, img.size() - 1);
      while (img.size() > cut) img.pop_back();
    end
  endtask

  // A lone byte, then the smallest container with a chunk: its final byte closes
  // the chunk header and ends the container, so it owes two words back to back.
  task automatic test_directed_edges();
    byte_q_t body;
    byte_q_t img;
    int      sent;
    sent = 0;
    send_byte(8'hFF, 1'b1);
    body = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    wrap_header(body, VERSION_ONE, HEADER_BYTES + 8, body_checksum(body), img);
    send_container(img, sent);
  endtask

  task automatic test_well_formed();
    byte_q_t img;
    int      sent;
    sent = 0;
    while (sent < 700) begin
      build_container(FAULT_NONE, 4, img);
      send_container(img, sent);
    end
  endtask

  // Rotate through every kind of damage so each shows up in turn.
  task automatic test_damaged_containers();
    byte_q_t img;
    int      sent;
    int      k;
    sent = 0;
    k = 0;
    while (sent < 600) begin
      build_container(fault_t'(FAULT_MAGIC + k % (FAULT_COUNT - 1)), 3, img);
      send_container(img, sent);
      k++;
    end
  endtask

  // Random byte runs; a third open with a good magic so the walker chews garbage.
  task automatic test_noise();
    byte_q_t img;
    int      sent;
    sent = 0;
    while (sent < 150) begin
      img = {};
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < 4; i++) img.push_back(MAGIC_WORD[8*i +: 8]);
      end
      repeat ($urandom_range(1, 40)) img.push_back(8'($urandom));
      send_container(img, sent);
    end
  endtask

  // Full rate on both sides, mixed good and damaged containers.
  task automatic test_back_to_back();
    byte_q_t img;
    int      sent;
    sent = 0;
    steady_flow = 1'b1;
    while (sent < 250) begin
      if ($urandom_range(0, 1)) build_container(FAULT_NONE, 4, img);
      else build_container(fault_t'($urandom_range(FAULT_MAGIC, FAULT_TRUNCATE)), 4, img);
      send_container(img, sent);
    end
    steady_flow = 1'b0;
  endtask

  // Result side: stall at random unless held at full rate.
  always @(negedge clk) begin
    out_ch.ready <= steady_flow || ($urandom_range(99) >= 37);
  end

  task automatic flag_word(input string what, input ccv_res_t want, input ccv_res_t seen);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s at cycle %0d", what, cycle_count);
      $display("  expected %s", word_text(want));
      $display("  actual   %s", word_text(seen));
    end
  endtask

  // Compare every accepted word against the oldest one owed.
  always @(posedge clk) begin : check_words
    ccv_res_t seen;
    ccv_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.result_kind    = out_ch.result_kind;
      seen.chunk_tag      = out_ch.chunk_tag;
      seen.chunk_length   = out_ch.chunk_length;
      seen.payload_offset = out_ch.payload_offset;
      seen.magic_ok       = out_ch.magic_ok;
      seen.version_ok     = out_ch.version_ok;
      seen.length_ok      = out_ch.length_ok;
      seen.crc_ok         = out_ch.crc_ok;
      seen.overrun_flag   = out_ch.overrun_flag;
      seen.last_of_run    = out_ch.last_of_run;
      if (awaited_words.size() == 0) begin
        flag_word("unexpected word", '0, seen);
      end else begin
        want = awaited_words.pop_front();
        if (seen !== want) flag_word("word mismatch", want, seen);
      end
    end
  end

  // Watchdog: a hung handshake or a missing word ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    steady_flow     = 1'b0;
    clear_tracker();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_well_formed();
    test_damaged_containers();
    test_noise();
    test_back_to_back();
    in_ch.valid <= 1'b0;

    // Drain what is owed, then watch a while longer for stray words.
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
